[hw/rtl/ndvi_pkg.sv]
// ----------------------------------------------------------------------------
// ndvi_pkg
// Shared constants and helpers of the NDVI pixel classifier.
// ----------------------------------------------------------------------------
package ndvi_pkg;

	localparam int Q_ONE = 16384;
	localparam logic [9:0] UNDEF_CODE = 10'd241;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LOW  = 2'd0,
		REG_WINDOW_HIGH = 2'd1,
		REG_TABLE_SIZE  = 2'd2
	} cfg_reg_t;

	// clamp a signed 16-bit window bound to [-1.0, +1.0] in Q1.14
	function automatic logic signed [15:0] sat_q(input logic signed [15:0] v);
		logic signed [15:0] r;
		r = v;
		if (v < -16'sd16384) begin
			r = -16'sd16384;
		end else if (v > 16'sd16384) begin
			r = 16'sd16384;
		end
		return r;
	endfunction

endpackage

[hw/rtl/ndvi_pixel_classifier_top.sv]
// ----------------------------------------------------------------------------
// ndvi_pixel_classifier_top
// Pipelined NDVI computation with window flag, magnitude code and colour
// table index. Rounding divisions are one quotient bit per stage.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | nir_sample, red_sample
//  out     | out_valid / out_ready | index_value, undefined, in_window,
//          |                       | magnitude_code, table_index
//  cfg     | cfg_we                | cfg_index, cfg_data
//
//  One pixel per cycle while the output is not stalled; the depth is set by
//  the NDVI divider (15 bits) and the table index divider.
//  Every stage holds its own valid bit and loads when it is empty or its
//  successor moves, so bubbles close up and a stalled output holds its beat.
//  arst_n clears valid bits and restores the default configuration.
// ----------------------------------------------------------------------------
module ndvi_pixel_classifier_top #(
	parameter int SAMPLE_BITS = 10,
	parameter int TABLE_MAX = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SAMPLE_BITS-1:0]              nir_sample,
	input  logic [SAMPLE_BITS-1:0]              red_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [15:0]                  index_value,
	output logic                                undefined,
	output logic                                in_window,
	output logic [9:0]                          magnitude_code,
	output logic [9:0]                          table_index,
	input  logic                                cfg_we,
	input  logic [ndvi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ndvi_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ndvi_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int SUMW = SB + 1;
	localparam int DAW = SUMW + 1;
	localparam int QA = 15;
	localparam int NAW = SB + 16;
	localparam int QM = 10;
	localparam int NMW = SB + 12;
	localparam int QB = (TABLE_MAX > 2) ? $clog2(TABLE_MAX) : 1;
	localparam int NBW = QB + 17;
	localparam int DBW = 17;
	localparam int MID = QA + 1;
	localparam int NST = QA + QB + 3;

	// configuration
	logic signed [15:0] win_lo_q, win_hi_q;
	logic [10:0] tsize_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_lo_q <= -16'sd16384;
			win_hi_q <= 16'sd16384;
			tsize_q <= 11'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LOW:  win_lo_q <= sat_q(cfg_data);
				REG_WINDOW_HIGH: win_hi_q <= sat_q(cfg_data);
				REG_TABLE_SIZE:  tsize_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// per-stage flow control
	logic [NST-1:0] vld_s;
	logic [NST:0] ld;

	assign ld[NST] = out_ready;
	for (genvar i = 0; i < NST; i++) begin : g_ld
		assign ld[i] = !vld_s[i] || ld[i+1];
	end
	assign in_ready = ld[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (ld[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// divider A stages: NDVI and magnitude quotients
	logic [NAW-1:0] ra_s [0:QA];
	logic [DAW-1:0] da_s [0:QA];
	logic [QA-1:0]  qa_s [0:QA];
	logic [NMW-1:0] rm_s [0:QA];
	logic [QM-1:0]  qm_s [0:QA];
	logic           neg_s [0:QA];
	logic           und_s [0:QA];

	logic [SUMW-1:0] sum_c;
	logic [SB-1:0] mabs_c;
	assign sum_c = SUMW'(nir_sample) + SUMW'(red_sample);
	assign mabs_c = (red_sample > nir_sample) ? red_sample - nir_sample
		: nir_sample - red_sample;

	// setup: round(n/d) as floor((2n + d) / 2d)
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			ra_s[0] <= NAW'({mabs_c, 15'd0}) + NAW'(sum_c);
			da_s[0] <= {sum_c, 1'b0};
			rm_s[0] <= NMW'(mabs_c) * NMW'(2046) + NMW'(sum_c);
			qa_s[0] <= '0;
			qm_s[0] <= '0;
			neg_s[0] <= red_sample > nir_sample;
			und_s[0] <= sum_c == '0;
		end
	end

	for (genvar j = 0; j < QA; j++) begin : g_diva
		localparam int K = QA - 1 - j;
		localparam int KM = (K < QM) ? K : 0;
		localparam bit MSTEP = K < QM;
		logic [NAW-1:0] dsh;
		logic [NMW-1:0] msh;
		logic ge_a, ge_m;
		assign dsh = NAW'(da_s[j]) << K;
		assign msh = NMW'(da_s[j]) << KM;
		assign ge_a = ra_s[j] >= dsh;
		assign ge_m = MSTEP && (rm_s[j] >= msh);
		always_ff @(posedge clk) begin
			if (ld[j+1]) begin
				da_s[j+1] <= da_s[j];
				neg_s[j+1] <= neg_s[j];
				und_s[j+1] <= und_s[j];
				ra_s[j+1] <= ge_a ? ra_s[j] - dsh : ra_s[j];
				qa_s[j+1] <= qa_s[j] | (QA'(ge_a) << K);
				rm_s[j+1] <= ge_m ? rm_s[j] - msh : rm_s[j];
				qm_s[j+1] <= qm_s[j] | (QM'(ge_m) << KM);
			end
		end
	end

	// middle stage: sign, window test, table index setup
	logic signed [15:0] q_c;
	logic signed [16:0] span_c, off_c;
	logic go_c;
	logic [QB-1:0] sm1_c;

	assign q_c = neg_s[QA] ? 16'(16'd0 - {1'b0, qa_s[QA]}) : {1'b0, qa_s[QA]};
	assign span_c = {win_hi_q[15], win_hi_q} - {win_lo_q[15], win_lo_q};
	assign off_c = {q_c[15], q_c} - {win_lo_q[15], win_lo_q};
	assign go_c = !und_s[QA] && (win_hi_q > win_lo_q) && (q_c > win_lo_q);

	always_comb begin
		if (tsize_q == '0) begin
			sm1_c = '0;
		end else if (32'(tsize_q) > TABLE_MAX) begin
			sm1_c = QB'(TABLE_MAX - 1);
		end else begin
			sm1_c = QB'(32'(tsize_q) - 32'd1);
		end
	end

	logic [NBW-1:0] rb_s [0:QB];
	logic [DBW-1:0] db_s [0:QB];
	logic [QB-1:0]  qb_s [0:QB];
	logic [QB-1:0]  sm1_s [0:QB];
	logic           go_s [0:QB];
	logic           full_s [0:QB];
	logic signed [15:0] q_s [0:QB];
	logic           win_s [0:QB];
	logic [9:0]     mag_s [0:QB];
	logic           und2_s [0:QB];

	always_ff @(posedge clk) begin
		if (ld[MID]) begin
			rb_s[0] <= NBW'({sm1_c, 1'b0}) * NBW'(off_c[15:0]) + NBW'(span_c[15:0]);
			db_s[0] <= {span_c[15:0], 1'b0};
			qb_s[0] <= '0;
			sm1_s[0] <= sm1_c;
			go_s[0] <= go_c;
			full_s[0] <= off_c[15:0] >= span_c[15:0];
			q_s[0] <= und_s[QA] ? 16'sd0 : q_c;
			win_s[0] <= !und_s[QA] && q_c >= win_lo_q && q_c <= win_hi_q;
			mag_s[0] <= und_s[QA] ? UNDEF_CODE : qm_s[QA];
			und2_s[0] <= und_s[QA];
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_divb
		localparam int K = QB - 1 - j;
		logic [NBW-1:0] dsh;
		logic ge_b;
		assign dsh = NBW'(db_s[j]) << K;
		assign ge_b = rb_s[j] >= dsh;
		always_ff @(posedge clk) begin
			if (ld[MID+1+j]) begin
				db_s[j+1] <= db_s[j];
				sm1_s[j+1] <= sm1_s[j];
				go_s[j+1] <= go_s[j];
				full_s[j+1] <= full_s[j];
				q_s[j+1] <= q_s[j];
				win_s[j+1] <= win_s[j];
				mag_s[j+1] <= mag_s[j];
				und2_s[j+1] <= und2_s[j];
				rb_s[j+1] <= ge_b ? rb_s[j] - dsh : rb_s[j];
				qb_s[j+1] <= qb_s[j] | (QB'(ge_b) << K);
			end
		end
	end

	// output register
	logic [QB-1:0] idx_c;
	logic [QB+9:0] idx_ext;
	assign idx_c = !go_s[QB] ? '0 : (full_s[QB] ? sm1_s[QB] : qb_s[QB]);
	assign idx_ext = {10'd0, idx_c};

	always_ff @(posedge clk) begin
		if (ld[NST-1]) begin
			index_value <= q_s[QB];
			undefined <= und2_s[QB];
			in_window <= win_s[QB];
			magnitude_code <= mag_s[QB];
			table_index <= idx_ext[9:0];
		end
	end

	assign out_valid = vld_s[NST-1];

	a_undef_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && undefined |-> magnitude_code == UNDEF_CODE
			&& index_value == 16'sd0 && table_index == 10'd0 && !in_window)
		else $error("undefined pixel with nonzero fields");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output side is free");

	a_ndvi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> index_value >= -16'sd16384 && index_value <= 16'sd16384)
		else $error("NDVI out of range");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(table_index)
			&& $stable(index_value))
		else $error("stalled result changed");

endmodule
